// ===== rtl/core/sct_pkg.sv =====
package sct_pkg;

  // Fixed-point formats
  localparam int FRAC     = 29;   // fraction bits of the polynomial datapath
  localparam int ANG_FRAC = 16;   // fraction bits of the input angle
  localparam int ANG_W    = 32;
  localparam int OUT_W    = 32;

  // Range reduction
  localparam int MAG_W = 18;      // |r| <= pi in Q16
  localparam int M_W   = 19;      // m in [0, 2pi)
  localparam int REM_W = 20;      // remainder before the last correction, < 4pi
  localparam int U_W   = 33;      // biased angle, always positive

  localparam logic [MAG_W-1:0] PI_Q16     = 18'd205887;
  localparam logic [M_W-1:0]   TWO_PI_Q16 = 19'd411774;

  // Whole turns added so that angle + pi is never negative
  localparam int RED_WRAPS = 5216;
  localparam logic [U_W-1:0] RED_BIAS =
    U_W'(64'(RED_WRAPS) * 64'(TWO_PI_Q16) + 64'(PI_Q16));

  // Quotient estimate: upper bits of u times 2^40 / 2pi
  localparam int UHI_SH  = 16;
  localparam int UHI_W   = U_W - UHI_SH;
  localparam int RREC_SH = 40;
  localparam int RREC_W  = 22;
  localparam logic [RREC_W-1:0] RED_RECIP =
    RREC_W'((64'd1 << RREC_SH) / 64'(TWO_PI_Q16));
  localparam int RPROD_W = UHI_W + RREC_W;
  localparam int QR_W    = RPROD_W - (RREC_SH - UHI_SH);

  // Square of the reduced angle
  localparam int SQ_W  = 2 * MAG_W;
  localparam int X2_SH = 2 * ANG_FRAC - FRAC;
  localparam int X2_W  = SQ_W - X2_SH;
  localparam int A_SH  = FRAC - ANG_FRAC;

  // Term datapath
  localparam int TERM_W = 32;     // every term stays below 2^32 for |x| <= pi
  localparam int SUM_W  = 36;
  localparam int P_W    = TERM_W + X2_W;
  localparam int S_W    = 36;     // rounded product before the divide by d
  localparam int SH_W   = 18;     // divide is done in two halves of this width
  localparam int D_W    = 8;      // largest d is 14*15
  localparam int X_W    = D_W + SH_W;

  localparam logic [TERM_W-1:0] ONE_Q29 = TERM_W'(1) << FRAC;

  // Payload travelling between the pipeline sections
  typedef struct packed {
    logic                     func;   // 1 = cosine
    logic                     neg;    // reduced angle was negative
    logic [X2_W-1:0]          x2;
    logic [TERM_W-1:0]        term;
    logic signed [SUM_W-1:0]  sum;
  } lane_t;

endpackage

// ===== rtl/core/sct_reduce.sv =====
module sct_reduce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic                          func_i,
  input  logic signed [sct_pkg::ANG_W-1:0] angle_i,
  output logic                          valid_o,
  output sct_pkg::lane_t                lane_o
);
  import sct_pkg::*;

  logic [6:0] v_q;

  logic [U_W-1:0]     u1_q, u2_q;
  logic [RPROD_W-1:0] prod2_q;
  logic [REM_W-1:0]   rem3_q;
  logic [M_W-1:0]     m4_q;
  logic [MAG_W-1:0]   mag5_q;
  logic [SQ_W-1:0]    sq6_q;
  logic [TERM_W-1:0]  term6_q;
  logic [6:1]         f_q;
  logic [6:5]         n_q;
  lane_t              lane7_q;

  logic [U_W-1:0]     u1_d;
  logic [RPROD_W-1:0] prod2_d;
  logic [QR_W-1:0]    q_est;
  logic [U_W-1:0]     qd;
  logic [U_W-1:0]     rem_full;
  logic [REM_W-1:0]   rem3_d;
  logic [M_W-1:0]     m4_d;
  logic [MAG_W-1:0]   mag5_d;
  logic               neg5_d;
  logic [SQ_W-1:0]    sq6_d;
  logic [TERM_W-1:0]  term6_d;
  lane_t              lane7_d;

  // Bias by an odd number of half turns, then estimate turns (low by at most one)
  always_comb begin
    u1_d     = U_W'(signed'({angle_i[ANG_W-1], angle_i})) + RED_BIAS;
    prod2_d  = RPROD_W'(u1_q[U_W-1:UHI_SH]) * RPROD_W'(RED_RECIP);
    q_est    = prod2_q[RPROD_W-1:RREC_SH-UHI_SH];
    qd       = U_W'(q_est) * U_W'(TWO_PI_Q16);
    rem_full = u2_q - qd;
    rem3_d   = rem_full[REM_W-1:0];
  end

  // Final correction, then fold into (-pi, pi]
  always_comb begin
    if (rem3_q >= REM_W'(TWO_PI_Q16)) begin
      m4_d = M_W'(rem3_q - REM_W'(TWO_PI_Q16));
    end else begin
      m4_d = M_W'(rem3_q);
    end

    priority if (m4_q == '0) begin
      // congruent to -pi: taken as +pi
      mag5_d = PI_Q16;
      neg5_d = 1'b0;
    end else if (m4_q >= M_W'(PI_Q16)) begin
      mag5_d = MAG_W'(m4_q - M_W'(PI_Q16));
      neg5_d = 1'b0;
    end else begin
      mag5_d = MAG_W'(M_W'(PI_Q16) - m4_q);
      neg5_d = 1'b1;
    end
  end

  // Square and first term, then rounded x^2 in Q29
  always_comb begin
    sq6_d   = SQ_W'(mag5_q) * SQ_W'(mag5_q);
    term6_d = f_q[5] ? ONE_Q29 : (TERM_W'(mag5_q) << A_SH);

    lane7_d.func = f_q[6];
    lane7_d.neg  = n_q[6];
    lane7_d.x2   = X2_W'((SQ_W'(sq6_q) + (SQ_W'(1) << (X2_SH - 1))) >> X2_SH);
    lane7_d.term = term6_q;
    lane7_d.sum  = '0;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q    <= u1_d;
      f_q[1]  <= func_i;
      prod2_q <= prod2_d;
      u2_q    <= u1_q;
      f_q[2]  <= f_q[1];
      rem3_q  <= rem3_d;
      f_q[3]  <= f_q[2];
      m4_q    <= m4_d;
      f_q[4]  <= f_q[3];
      mag5_q  <= mag5_d;
      n_q[5]  <= neg5_d;
      f_q[5]  <= f_q[4];
      sq6_q   <= sq6_d;
      term6_q <= term6_d;
      n_q[6]  <= n_q[5];
      f_q[6]  <= f_q[5];
      lane7_q <= lane7_d;
    end
  end

  assign valid_o = v_q[6];
  assign lane_o  = lane7_q;

endmodule

// ===== rtl/core/sct_term.sv =====
module sct_term #(
  parameter int K = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sct_pkg::lane_t lane_i,
  output logic           valid_o,
  output sct_pkg::lane_t lane_o
);
  import sct_pkg::*;

  // Divisors for this term and reciprocals for the two divide halves
  localparam int DSIN = 2 * K * (2 * K + 1);
  localparam int DCOS = 2 * K * (2 * K - 1);
  localparam logic [SH_W-1:0] R1SIN = SH_W'((1 << SH_W) / DSIN);
  localparam logic [SH_W-1:0] R1COS = SH_W'((1 << SH_W) / DCOS);
  localparam logic [X_W-1:0]  R2SIN = X_W'((1 << X_W) / DSIN);
  localparam logic [X_W-1:0]  R2COS = X_W'((1 << X_W) / DCOS);
  // incoming term has index K-1: added when that index is even
  localparam bit ADD_IN = (K % 2) == 1;

  logic [5:0] v_q;
  lane_t      l_q [6];

  logic [P_W-1:0]    p0_q;
  logic [S_W-1:0]    s1_q;
  logic [2*SH_W-1:0] pr2_q;
  logic [SH_W-1:0]   hi2_q, lo2_q, lo3_q;
  logic [SH_W-1:0]   q13_q, q14_q;
  logic [D_W-1:0]    r13_q;
  logic [X_W-1:0]    x4_q;
  logic [2*X_W-1:0]  pr4_q;

  logic signed [SUM_W-1:0] tin;
  lane_t             l0_d, l5_d;
  logic [P_W-1:0]    p0_d;
  logic [P_W:0]      ps1;
  logic [D_W-1:0]    d1, d3, d5;
  logic [S_W-1:0]    s1_d;
  logic [SH_W-1:0]   r1_2;
  logic [2*SH_W-1:0] pr2_d;
  logic [SH_W-1:0]   q1e;
  logic [X_W-1:0]    chk1, rem1;
  logic [SH_W-1:0]   q13_d;
  logic [D_W-1:0]    r13_d;
  logic [X_W-1:0]    x4_d;
  logic [X_W-1:0]    r2_4;
  logic [2*X_W-1:0]  pr4_d;
  logic [X_W-1:0]    q2e;
  logic [X_W+D_W-1:0] chk2, rem2;
  logic [X_W-1:0]    q2;

  // Stage 0: accumulate incoming term, product term * x^2
  always_comb begin
    tin  = signed'(SUM_W'(lane_i.term));
    l0_d = lane_i;
    l0_d.sum = ADD_IN ? lane_i.sum + tin : lane_i.sum - tin;
    p0_d = P_W'(lane_i.term) * P_W'(lane_i.x2);
  end

  // Stage 1: shift to Q29 with half of d added, so the divide below rounds
  always_comb begin
    d1   = l_q[0].func ? D_W'(DCOS) : D_W'(DSIN);
    ps1  = {1'b0, p0_q} + ((P_W + 1)'(d1) << (FRAC - 1));
    s1_d = ps1[FRAC+S_W-1:FRAC];
  end

  // Stage 2: quotient estimate for the upper half
  always_comb begin
    r1_2  = l_q[1].func ? R1COS : R1SIN;
    pr2_d = (2*SH_W)'(s1_q[S_W-1:SH_W]) * (2*SH_W)'(r1_2);
  end

  // Stage 3: correct upper quotient, keep its remainder
  always_comb begin
    d3   = l_q[2].func ? D_W'(DCOS) : D_W'(DSIN);
    q1e  = pr2_q[2*SH_W-1:SH_W];
    chk1 = X_W'(q1e) * X_W'(d3);
    rem1 = X_W'(hi2_q) - chk1;
    if (rem1 >= X_W'(d3)) begin
      q13_d = q1e + SH_W'(1);
      r13_d = D_W'(rem1 - X_W'(d3));
    end else begin
      q13_d = q1e;
      r13_d = D_W'(rem1);
    end
  end

  // Stage 4: quotient estimate for the lower half
  always_comb begin
    x4_d  = {r13_q, lo3_q};
    r2_4  = l_q[3].func ? R2COS : R2SIN;
    pr4_d = (2*X_W)'(x4_d) * (2*X_W)'(r2_4);
  end

  // Stage 5: correct lower quotient and join the halves
  always_comb begin
    d5   = l_q[4].func ? D_W'(DCOS) : D_W'(DSIN);
    q2e  = pr4_q[2*X_W-1:X_W];
    chk2 = (X_W+D_W)'(q2e) * (X_W+D_W)'(d5);
    rem2 = (X_W+D_W)'(x4_q) - chk2;
    q2   = (rem2 >= (X_W+D_W)'(d5)) ? q2e + X_W'(1) : q2e;
    l5_d = l_q[4];
    l5_d.term = TERM_W'({q14_q, q2[SH_W-1:0]});
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q[0] <= l0_d;
      p0_q   <= p0_d;
      l_q[1] <= l_q[0];
      s1_q   <= s1_d;
      l_q[2] <= l_q[1];
      pr2_q  <= pr2_d;
      hi2_q  <= s1_q[S_W-1:SH_W];
      lo2_q  <= s1_q[SH_W-1:0];
      l_q[3] <= l_q[2];
      q13_q  <= q13_d;
      r13_q  <= r13_d;
      lo3_q  <= lo2_q;
      l_q[4] <= l_q[3];
      x4_q   <= x4_d;
      pr4_q  <= pr4_d;
      q14_q  <= q13_q;
      l_q[5] <= l5_d;
    end
  end

  assign valid_o = v_q[5];
  assign lane_o  = l_q[5];

endmodule

// ===== rtl/core/sct_out.sv =====
module sct_out #(
  parameter int TERMS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  sct_pkg::lane_t                lane_i,
  input  logic                          stall_i,
  output logic                          en_o,
  output logic                          valid_o,
  output logic signed [sct_pkg::OUT_W-1:0] value_o
);
  import sct_pkg::*;

  localparam bit LAST_ADD = ((TERMS - 1) % 2) == 0;
  localparam logic signed [SUM_W+1:0] SAT_MAX = (SUM_W+2)'(32'sh7fff_ffff);
  localparam logic signed [SUM_W+1:0] SAT_MIN = (SUM_W+2)'(32'sh8000_0000);

  logic                    f_v_q;
  logic signed [SUM_W-1:0] f_sum_q;
  logic                    f_neg_q;
  logic                    out_v_q, skid_v_q;
  logic signed [OUT_W-1:0] out_q, skid_q;

  logic signed [SUM_W-1:0] tin, f_sum_d;
  logic signed [SUM_W:0]   nsum;
  logic signed [SUM_W+1:0] dbl;
  logic signed [OUT_W-1:0] sat;
  logic                    en, push, pop;
  logic                    out_v_d, skid_v_d;
  logic                    ld_out, ld_skid, out_from_skid;

  // Last term into the sum
  always_comb begin
    tin     = signed'(SUM_W'(lane_i.term));
    f_sum_d = LAST_ADD ? lane_i.sum + tin : lane_i.sum - tin;
  end

  // Odd symmetry for sine, Q29 to Q30, saturate
  always_comb begin
    nsum = f_neg_q ? -((SUM_W+1)'(f_sum_q)) : (SUM_W+1)'(f_sum_q);
    dbl  = {nsum, 1'b0};
    priority if (dbl > SAT_MAX) begin
      sat = OUT_W'(SAT_MAX);
    end else if (dbl < SAT_MIN) begin
      sat = OUT_W'(SAT_MIN);
    end else begin
      sat = dbl[OUT_W-1:0];
    end
  end

  // Two-beat output buffer: pipeline runs until the skid entry is taken
  always_comb begin
    en            = !skid_v_q;
    push          = en && f_v_q;
    pop           = out_v_q && !stall_i;
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    ld_out        = 1'b0;
    ld_skid       = 1'b0;
    out_from_skid = 1'b0;
    priority if (!out_v_q || pop) begin
      if (skid_v_q) begin
        ld_out        = 1'b1;
        out_from_skid = 1'b1;
        out_v_d       = 1'b1;
        skid_v_d      = 1'b0;
      end else begin
        ld_out  = push;
        out_v_d = push;
      end
    end else begin
      if (push) begin
        ld_skid  = 1'b1;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        f_v_q <= valid_i;
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_sum_q <= f_sum_d;
      f_neg_q <= lane_i.neg && !lane_i.func;
    end
    if (ld_out) begin
      out_q <= out_from_skid ? skid_q : sat;
    end
    if (ld_skid) begin
      skid_q <= sat;
    end
  end

  assign en_o    = en;
  assign valid_o = out_v_q;
  assign value_o = out_q;

endmodule

// ===== rtl/core/sine_cosine_taylor.sv =====
// Sine / cosine by truncated Taylor series, fully pipelined.
// Throughput: one angle per cycle while stall_o is low; each further term adds a
// six-stage section (product, rounding add, two reciprocal-multiply divide halves
// with their corrections).
// stall_o rises only while both entries of the two-beat output buffer are held.
// Reset clears the valid bits only; no state otherwise, no clearing pass.
module sine_cosine_taylor #(
  parameter int TERMS = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic                             func_i,
  input  logic signed [sct_pkg::ANG_W-1:0] angle_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic signed [sct_pkg::OUT_W-1:0] value_o
);
  import sct_pkg::*;

  logic             en;
  logic [TERMS-1:0] lane_v;
  lane_t            lane [TERMS];

  // Range reduction and x^2
  sct_reduce u_reduce (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i,
    .func_i,
    .angle_i,
    .valid_o (lane_v[0]),
    .lane_o  (lane[0])
  );

  // One section per further term
  for (genvar k = 1; k < TERMS; k++) begin : g_term
    sct_term #(
      .K (k)
    ) u_term (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .valid_i (lane_v[k-1]),
      .lane_i  (lane[k-1]),
      .valid_o (lane_v[k]),
      .lane_o  (lane[k])
    );
  end

  // Final sum, saturation and output buffer
  sct_out #(
    .TERMS (TERMS)
  ) u_out (
    .clk_i,
    .rst_ni,
    .valid_i (lane_v[TERMS-1]),
    .lane_i  (lane[TERMS-1]),
    .stall_i,
    .en_o    (en),
    .valid_o,
    .value_o
  );

  assign stall_o = !en;

  // Input is held off only while a result is waiting downstream
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("stall_o high with no result beat pending");

  // The buffer fills only in a cycle where the output beat was held
  a_fill_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("output buffer filled without a held output beat");

  // A full buffer with a held output stays full
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stall_o && stall_i) |=> stall_o)
    else $error("output buffer drained while output was stalled");

endmodule

// ===== bench/sine_cosine_taylor_test.sv =====
module sine_cosine_taylor_test;

  localparam int  TERMS       = 5;
  localparam int  LATENCY     = 6 * TERMS + 2;
  localparam int  DRAIN_LIMIT = 20000;
  localparam int  RUN_LIMIT   = 2000000;
  localparam int  RANDOM_BEATS = 700;
  localparam int  WRAP_BEATS   = 200;
  localparam int  BURST_BEATS  = 100;
  localparam logic FUNC_SINE   = 1'b0;
  localparam logic FUNC_COSINE = 1'b1;

  localparam longint PI_Q     = longint'(sct_pkg::PI_Q16);
  localparam longint TWO_PI_Q = longint'(sct_pkg::TWO_PI_Q16);
  localparam int     POLY_FRAC = sct_pkg::FRAC;
  localparam int     MAG_SHIFT = sct_pkg::FRAC - sct_pkg::ANG_FRAC;

  typedef struct {
    logic                             func;
    logic signed [sct_pkg::ANG_W-1:0] angle;
    logic signed [sct_pkg::OUT_W-1:0] value;
  } value_entry_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             valid_i;
  logic                             stall_o;
  logic                             func_i;
  logic signed [sct_pkg::ANG_W-1:0] angle_i;
  logic                             valid_o;
  logic                             stall_i;
  logic signed [sct_pkg::OUT_W-1:0] value_o;

  value_entry_t pending_values[$];
  int           mismatch_count = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_quiet = 1'b0;

  sine_cosine_taylor #(
    .TERMS(TERMS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .func_i (func_i),
    .angle_i(angle_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .value_o(value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected sine or cosine of one angle, Q2.30, saturated
  function automatic logic signed [31:0] taylor_value(input logic cosine,
                                                      input logic signed [31:0] ang);
    longint          wide_ang, biased, turn_pos, reduced, sum, q30;
    longint unsigned mag, x2, term, den;
    int              k;
    wide_ang = ang;
    biased   = wide_ang + PI_Q;
    turn_pos = biased % TWO_PI_Q;
    if (turn_pos < 0) turn_pos += TWO_PI_Q;
    reduced = turn_pos - PI_Q;
    // angle congruent to -pi lands on +pi
    if (reduced == -PI_Q) reduced = PI_Q;
    mag  = longint'(reduced < 0 ? -reduced : reduced) << MAG_SHIFT;
    x2   = (mag * mag + (64'd1 << (POLY_FRAC - 1))) >> POLY_FRAC;
    term = cosine ? (64'd1 << POLY_FRAC) : mag;
    sum  = longint'(term);
    for (k = 1; k < TERMS; k++) begin
      den  = (cosine ? longint'((2 * k - 1) * (2 * k)) : longint'((2 * k) * (2 * k + 1)))
             << POLY_FRAC;
      term = (term * x2 + den / 2) / den;
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    // odd polynomial: sign follows the angle
    if (!cosine && reduced < 0) sum = -sum;
    q30 = sum * 2;
    if (q30 > 64'sd2147483647)  q30 = 64'sd2147483647;
    if (q30 < -64'sd2147483648) q30 = -64'sd2147483648;
    return q30[31:0];
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Send one beat; junk payload while idle, held payload while stalled
  task automatic send_angle(input logic cosine, input logic signed [31:0] ang);
    int           gap;
    value_entry_t entry;
    gap = tx_gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
      func_i  <= 1'($urandom);
      angle_i <= $urandom;
    end
    @(negedge clk_i);
    valid_i <= 1'b1;
    func_i  <= cosine;
    angle_i <= ang;
    forever begin
      @(posedge clk_i);
      if (!stall_o) break;
    end
    entry.func  = cosine;
    entry.angle = ang;
    entry.value = taylor_value(cosine, ang);
    pending_values.push_back(entry);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    valid_i <= 1'b0;
  endtask

  // Field extremes, boundaries around +-pi, both functions
  task automatic test_boundaries();
    logic signed [31:0] angles[13];
    angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
               32'(PI_Q), 32'(-PI_Q), 32'(PI_Q - 1), 32'(-PI_Q + 1),
               32'(PI_Q + 1), 32'(3 * PI_Q), 32'(TWO_PI_Q), 32'(PI_Q / 2)};
    foreach (angles[i]) begin
      send_angle(FUNC_SINE, angles[i]);
      send_angle(FUNC_COSINE, angles[i]);
    end
  endtask

  // Full-range random angles, random function
  task automatic test_random_angles();
    repeat (RANDOM_BEATS) send_angle(1'($urandom), $urandom);
  endtask

  // Angles close to the wrap point of many turns, and small angles within two turns
  task automatic test_near_wrap();
    longint turns, offset, ang;
    repeat (WRAP_BEATS) begin
      if ($urandom_range(0, 1)) begin
        turns  = longint'($urandom_range(0, 10000)) - 5000;
        offset = longint'($urandom_range(0, 8)) - 4;
        ang    = turns * TWO_PI_Q + ($urandom_range(0, 1) ? PI_Q : -PI_Q) + offset;
      end else begin
        ang = longint'($urandom_range(0, 8 * PI_Q)) - 4 * PI_Q;
      end
      send_angle(1'($urandom), 32'(ang));
    end
  endtask

  // Back-to-back beats with neither side idling
  task automatic test_back_to_back();
    tx_gaps_on = 1'b0;
    rx_quiet   = 1'b1;
    repeat (BURST_BEATS) send_angle(1'($urandom), $urandom);
    tx_gaps_on = 1'b1;
    rx_quiet   = 1'b0;
  endtask

  // Output side: alternating stall and run segments of random length
  initial begin : rx_stall_gen
    int seg;
    bit hold;
    stall_i = 1'b0;
    seg     = 0;
    hold    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_quiet) begin
        hold = 1'b0;
        seg  = 0;
      end else if (seg == 0) begin
        hold = !hold;
        seg  = hold ? pick_gap() + 1 : pick_gap() * 4 + 1;
      end
      stall_i <= hold;
      if (seg > 0) seg--;
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    value_entry_t entry;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h", value_o));
      end else begin
        entry = pending_values.pop_front();
        if (value_o !== entry.value)
          report_mismatch($sformatf("func=%0d angle=%h value=%h expected=%h",
                                    entry.func, entry.angle, value_o, entry.value));
      end
    end
  end

  initial begin : run
    int waited;
    rst_ni  = 1'b0;
    valid_i = 1'b0;
    func_i  = 1'b0;
    angle_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_boundaries();
    test_random_angles();
    test_near_wrap();
    test_back_to_back();
    release_input();

    // drain, then watch for stray beats
    waited = 0;
    while (pending_values.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    if (pending_values.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", pending_values.size()));

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
